// ===== hdl/vad_pkg.sv =====
// ----------------------------------------------------------------------------
// vad_pkg
// Shared constants, field widths and result codes of the vertex attribute
// de-duplication table.
// ----------------------------------------------------------------------------
package vad_pkg;

    // Default table geometry
    localparam int MAX_SLOTS_DEF       = 4096;
    localparam int ATTR_INDEX_BITS_DEF = 16;

    // Fixed field widths of the stream items and the register
    localparam int POS_W    = 12;
    localparam int ATTR_W   = 16;
    localparam int BASE_W   = 13;
    localparam int SLOT_W   = 12;
    localparam int OUTC_W   = 3;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    typedef logic [OUTC_W-1:0] t_outcome;

    localparam t_outcome OUT_REUSED   = 3'd0;
    localparam t_outcome OUT_BASE     = 3'd1;
    localparam t_outcome OUT_APPENDED = 3'd2;
    localparam t_outcome OUT_FULL     = 3'd3;
    localparam t_outcome OUT_BADPOS   = 3'd4;

endpackage

// ===== hdl/vertex_attribute_dedup.sv =====
// ----------------------------------------------------------------------------
// vertex_attribute_dedup
// Sequence: IDLE takes an item and reads its base slot, LOOK compares the word
//   read and follows one chain link per table read, APPEND writes the new slot
//   on an append, DONE loads the output register once it is free. A new item is
//   taken only in IDLE; the single read port serves one chain step per read.
// Reset (synchronous, active low): clears the register, the append count and the
//   output, then a pass clears every valid mark; items wait.
// ----------------------------------------------------------------------------
module vertex_attribute_dedup #(
    parameter int MAX_SLOTS       = vad_pkg::MAX_SLOTS_DEF,
    parameter int ATTR_INDEX_BITS = vad_pkg::ATTR_INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Configuration: base_count
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vad_pkg::BASE_W-1:0]     i_cfg_data,

    // Corner items in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [11:0] corner_position, [27:12] corner_texcoord, [43:28] corner_normal,
    // [47:44] zero
    input  logic [vad_pkg::S_TDATA_W-1:0]  s_axis_tdata,

    // Result items out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [11:0] vertex_slot, [23:12] copy_from_position
    output logic [vad_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [2:0] outcome
    output logic [vad_pkg::OUTC_W-1:0]     m_axis_tuser
);

    // ------------------------------------------------------------------
    // Derived widths
    //   SW: slot address, LW: link (slot + 1, zero ends the chain) and
    //   step count, NW: next-free arithmetic with headroom.
    // ------------------------------------------------------------------
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int LW = $clog2(MAX_SLOTS + 1);
    localparam int NW = ((LW > vad_pkg::BASE_W) ? LW : vad_pkg::BASE_W) + 1;
    localparam int AB = ATTR_INDEX_BITS;

    // Table word: {valid, texcoord, normal, link}
    localparam int WW    = 1 + 2 * AB + LW;
    localparam int LNK_L = 0;
    localparam int NM_L  = LW;
    localparam int TC_L  = LW + AB;
    localparam int VLD_B = LW + 2 * AB;

    // Sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]                  r_state,       n_state;
    logic [SW-1:0]               r_clr_addr,    n_clr_addr;
    logic [vad_pkg::BASE_W-1:0]  r_base_count,  n_base_count;
    logic [vad_pkg::BASE_W-1:0]  r_appended,    n_appended;
    logic                        r_m_valid,     n_m_valid;

    logic [vad_pkg::POS_W-1:0]   r_pos,         n_pos;
    logic [AB-1:0]               r_tc,          n_tc;
    logic [AB-1:0]               r_nm,          n_nm;
    logic [SW-1:0]               r_cur,         n_cur;
    logic [LW-1:0]               r_steps,       n_steps;
    logic                        r_first,       n_first;
    logic                        r_cut,         n_cut;
    logic [SW-1:0]               r_next,        n_next;
    logic [vad_pkg::SLOT_W-1:0]  r_res_slot,    n_res_slot;
    vad_pkg::t_outcome           r_res_outcome, n_res_outcome;
    logic [vad_pkg::POS_W-1:0]   r_res_from,    n_res_from;
    logic [vad_pkg::M_TDATA_W-1:0] r_m_tdata,   n_m_tdata;
    logic [vad_pkg::OUTC_W-1:0]  r_m_tuser,     n_m_tuser;

    // Table port
    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    logic [WW-1:0]   ram_wdata;
    logic            ram_re;
    logic [SW-1:0]   ram_raddr;
    logic [WW-1:0]   ram_rdata;

    // Fields of the word read in the previous cycle
    logic            w_valid;
    logic [AB-1:0]   w_tc;
    logic [AB-1:0]   w_nm;
    logic [LW-1:0]   w_link;
    logic            w_match;
    logic            w_link_ok;

    // Table bounds
    logic [NW-1:0]   eff_base;
    logic [NW-1:0]   next_free;
    logic            pos_bad;
    logic            table_full;

    logic            in_take;

    // ------------------------------------------------------------------
    // Slot table. The sequencer never reads in a cycle right after a write
    // to the same item's slots: item writes happen only in LOOK/APPEND, which
    // are always followed by APPEND or DONE, so no forwarding is needed.
    // ------------------------------------------------------------------
    vad_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (WW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_valid = ram_rdata[VLD_B];
    assign w_tc    = ram_rdata[TC_L +: AB];
    assign w_nm    = ram_rdata[NM_L +: AB];
    assign w_link  = ram_rdata[LNK_L +: LW];

    assign w_match   = (w_tc == r_tc) && (w_nm == r_nm);
    assign w_link_ok = (w_link != '0) && (w_link <= LW'(MAX_SLOTS));

    // Register values above the table size act as the table size
    assign eff_base   = (NW'(r_base_count) > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS)
                                                             : NW'(r_base_count);
    assign next_free  = eff_base + NW'(r_appended);
    assign pos_bad    = NW'(r_pos) >= eff_base;
    assign table_full = next_free >= NW'(MAX_SLOTS);

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // ------------------------------------------------------------------
    // Sequencer: read a slot, compare, follow the link or write back
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_base_count  = r_base_count;
        n_appended    = r_appended;
        n_m_valid     = r_m_valid;
        n_pos         = r_pos;
        n_tc          = r_tc;
        n_nm          = r_nm;
        n_cur         = r_cur;
        n_steps       = r_steps;
        n_first       = r_first;
        n_cut         = r_cut;
        n_next        = r_next;
        n_res_slot    = r_res_slot;
        n_res_outcome = r_res_outcome;
        n_res_from    = r_res_from;
        n_m_tdata     = r_m_tdata;
        n_m_tuser     = r_m_tuser;

        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = SW'(s_axis_tdata[vad_pkg::POS_W-1:0]);

        // Configuration lands in the register at once
        if (i_cfg_valid) begin
            n_base_count = i_cfg_data;
        end

        // Drop the output item once taken
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Sweep every slot, one per cycle, clearing its valid mark
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_take) begin
                    // Capture the corner and read its base slot
                    ram_re  = 1'b1;
                    n_pos   = s_axis_tdata[vad_pkg::POS_W-1:0];
                    n_tc    = AB'(s_axis_tdata[vad_pkg::POS_W +: vad_pkg::ATTR_W]);
                    n_nm    = AB'(s_axis_tdata[vad_pkg::POS_W + vad_pkg::ATTR_W +:
                                               vad_pkg::ATTR_W]);
                    n_cur   = SW'(s_axis_tdata[vad_pkg::POS_W-1:0]);
                    n_steps = '0;
                    n_first = 1'b1;
                    n_cut   = 1'b0;
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                n_first = 1'b0;
                if (r_first && pos_bad) begin
                    n_res_slot    = '0;
                    n_res_outcome = vad_pkg::OUT_BADPOS;
                    n_res_from    = '0;
                    n_state       = S_DONE;
                end else if (r_first && !w_valid) begin
                    // First use of the position: claim its base slot
                    ram_we        = 1'b1;
                    ram_waddr     = SW'(r_pos);
                    ram_wdata     = {1'b1, r_tc, r_nm, LW'(0)};
                    n_res_slot    = r_pos;
                    n_res_outcome = vad_pkg::OUT_BASE;
                    n_res_from    = r_pos;
                    n_state       = S_DONE;
                end else if (!r_cut && w_match) begin
                    n_res_slot    = vad_pkg::SLOT_W'(r_cur);
                    n_res_outcome = vad_pkg::OUT_REUSED;
                    n_res_from    = '0;
                    n_state       = S_DONE;
                end else if (!r_cut && w_link_ok) begin
                    // Advance along the chain; the last allowed step is
                    // read but not compared
                    ram_re    = 1'b1;
                    ram_raddr = SW'(w_link - LW'(1));
                    n_cur     = SW'(w_link - LW'(1));
                    n_steps   = r_steps + 1'b1;
                    n_cut     = (r_steps == LW'(MAX_SLOTS - 1));
                end else if (table_full) begin
                    n_res_slot    = '0;
                    n_res_outcome = vad_pkg::OUT_FULL;
                    n_res_from    = '0;
                    n_state       = S_DONE;
                end else begin
                    // Link the chain tail to the new slot, keep its fields
                    ram_we    = 1'b1;
                    ram_waddr = r_cur;
                    ram_wdata = {w_valid, w_tc, w_nm, LW'(next_free + NW'(1))};
                    n_next    = SW'(next_free);
                    n_state   = S_APPEND;
                end
            end

            S_APPEND: begin
                ram_we        = 1'b1;
                ram_waddr     = r_next;
                ram_wdata     = {1'b1, r_tc, r_nm, LW'(0)};
                n_appended    = r_appended + 1'b1;
                n_res_slot    = vad_pkg::SLOT_W'(r_next);
                n_res_outcome = vad_pkg::OUT_APPENDED;
                n_res_from    = r_pos;
                n_state       = S_DONE;
            end

            S_DONE: begin
                // Hold the result until the output register is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tdata = {r_res_from, r_res_slot};
                    n_m_tuser = r_res_outcome;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_base_count <= '0;
            r_appended   <= '0;
            r_m_valid    <= 1'b0;
            r_first      <= 1'b0;
            r_cut        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_base_count <= n_base_count;
            r_appended   <= n_appended;
            r_m_valid    <= n_m_valid;
            r_first      <= n_first;
            r_cut        <= n_cut;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pos         <= n_pos;
        r_tc          <= n_tc;
        r_nm          <= n_nm;
        r_cur         <= n_cur;
        r_steps       <= n_steps;
        r_next        <= n_next;
        r_res_slot    <= n_res_slot;
        r_res_outcome <= n_res_outcome;
        r_res_from    <= n_res_from;
        r_m_tdata     <= n_m_tdata;
        r_m_tuser     <= n_m_tuser;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_take_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during clearing pass");

    a_done_loads_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_m_valid || m_axis_tready)) |=>
            (r_m_valid && r_state == S_IDLE))
        else $error("finished result not loaded into output register");

    a_append_counts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |=> (r_appended == $past(r_appended) + 1'b1))
        else $error("append count not advanced on append");

    a_no_write_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !ram_we)
        else $error("table written outside of a walk");

endmodule

// ===== hdl/vad_ram.sv =====
// ----------------------------------------------------------------------------
// vad_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module vad_ram #(
    parameter int DEPTH = vad_pkg::MAX_SLOTS_DEF,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/tb_vertex_attribute_dedup.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_attribute_dedup
// Self-checking bench for the vertex attribute de-duplication table. A short
// table of directed corners and base_count writes (bad positions, first use,
// reuse, appends, chain breaks after lowering base_count, a full table) runs
// first, then three randomized phases of corners drawn mostly from a few hot
// positions and attribute pools. Each result item is compared with its typed
// row's expected result or a bench-side copy of the table, with random idling.
// ----------------------------------------------------------------------------
module tb_vertex_attribute_dedup;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = vad_pkg::MAX_SLOTS_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 195;      // per random phase
    localparam int SETTLE     = 32;       // quiet cycles after the last result

    typedef struct packed {
        logic [vad_pkg::POS_W-1:0]  position;
        logic [vad_pkg::ATTR_W-1:0] texcoord;
        logic [vad_pkg::ATTR_W-1:0] normal;
    } t_corner;

    typedef struct packed {
        logic [vad_pkg::SLOT_W-1:0] vertex_slot;
        vad_pkg::t_outcome          outcome;
        logic [vad_pkg::POS_W-1:0]  copy_from;
    } t_slot_result;

    typedef enum logic { ROW_CFG, ROW_CORNER } t_row_kind;

    // One directed step: either a base_count write or a corner. Rows with
    // typed set carry their expected result; the rest go to the predictor.
    typedef struct packed {
        t_row_kind                  kind;
        logic [vad_pkg::BASE_W-1:0] base;
        logic [vad_pkg::POS_W-1:0]  position;
        logic [vad_pkg::ATTR_W-1:0] texcoord;
        logic [vad_pkg::ATTR_W-1:0] normal;
        logic                       typed;
        logic [vad_pkg::SLOT_W-1:0] w_slot;
        vad_pkg::t_outcome          w_outcome;
        logic [vad_pkg::POS_W-1:0]  w_from;
    } t_plan_row;

    localparam int PLAN_LEN = 25;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // reset value is zero, write it anyway: every position is out of range
        '{ROW_CFG, 13'd0, 12'd0, 16'h0, 16'h0, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd0, 16'h0, 16'h0, 1'b1, 12'd0, vad_pkg::OUT_BADPOS, 12'd0},
        '{ROW_CORNER, 13'd0, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'd0, vad_pkg::OUT_BADPOS,
          12'd0},
        '{ROW_CFG, 13'd8, 12'd0, 16'h0, 16'h0, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        // position equal to base_count is still out of range
        '{ROW_CORNER, 13'd0, 12'd8, 16'h1234, 16'h4321, 1'b1, 12'd0, vad_pkg::OUT_BADPOS,
          12'd0},
        '{ROW_CORNER, 13'd0, 12'd0, 16'h0, 16'h0, 1'b1, 12'd0, vad_pkg::OUT_BASE, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd7, 16'hFFFF, 16'hFFFF, 1'b1, 12'd7, vad_pkg::OUT_BASE, 12'd7},
        '{ROW_CORNER, 13'd0, 12'd0, 16'h0, 16'h0, 1'b1, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        // first duplicate lands right after the base slots
        '{ROW_CORNER, 13'd0, 12'd0, 16'h1, 16'h0, 1'b1, 12'd8, vad_pkg::OUT_APPENDED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd0, 16'h0, 16'h1, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd0, 16'h0, 16'h1, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd7, 16'hAAAA, 16'h5555, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd7, 16'h5555, 16'hAAAA, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        // lower base_count: the next appends overwrite live duplicate slots
        '{ROW_CFG, 13'd4, 12'd0, 16'h0, 16'h0, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd7, 16'hAAAA, 16'h5555, 1'b1, 12'd0, vad_pkg::OUT_BADPOS, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd3, 16'h3, 16'h3, 1'b1, 12'd3, vad_pkg::OUT_BASE, 12'd3},
        '{ROW_CORNER, 13'd0, 12'd3, 16'h4, 16'h4, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd0, 16'h0, 16'h1, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'd0, 16'h1, 16'h0, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        // all slots are base slots: any new duplicate overflows
        '{ROW_CFG, 13'd4096, 12'd0, 16'h0, 16'h0, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'hFFF, 16'h0, 16'h0, 1'b1, 12'hFFF, vad_pkg::OUT_BASE, 12'hFFF},
        '{ROW_CORNER, 13'd0, 12'hFFF, 16'h1, 16'h0, 1'b1, 12'd0, vad_pkg::OUT_FULL, 12'd0},
        // above the table size acts as the table size
        '{ROW_CFG, 13'd8191, 12'd0, 16'h0, 16'h0, 1'b0, 12'd0, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'hFFF, 16'h0, 16'h0, 1'b1, 12'hFFF, vad_pkg::OUT_REUSED, 12'd0},
        '{ROW_CORNER, 13'd0, 12'hFFF, 16'h2, 16'h2, 1'b1, 12'd0, vad_pkg::OUT_FULL, 12'd0}
    };

    // ------------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [vad_pkg::BASE_W-1:0]    i_cfg_data    = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [vad_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [vad_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [vad_pkg::OUTC_W-1:0]    m_axis_tuser;

    vertex_attribute_dedup u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench copy of the slot table
    // ------------------------------------------------------------------------
    logic [vad_pkg::BASE_W-1:0] base_reg;
    logic                       slot_live [SLOTS];
    logic [vad_pkg::ATTR_W-1:0] slot_tex  [SLOTS];
    logic [vad_pkg::ATTR_W-1:0] slot_nrm  [SLOTS];
    logic [vad_pkg::BASE_W-1:0] slot_next [SLOTS];   // successor + 1, zero ends the chain
    logic [vad_pkg::BASE_W-1:0] appended;

    t_slot_result pending_slots [$];        // results still owed by the DUT
    int           n_corners = 0;            // corners accepted (NBA only)
    int           n_results = 0;            // results accepted (NBA only)
    int           n_bases   = 0;            // base_count writes
    int           mismatches = 0;
    int           seen_outcome [5] = '{default: 0};
    int           tx_idle_pct = 16;
    int           rx_idle_pct = 61;
    int unsigned  cycles = 0;

    function automatic void claim_slot(int unsigned s, logic [vad_pkg::ATTR_W-1:0] tc,
                                       logic [vad_pkg::ATTR_W-1:0] nm);
        slot_live[s] = 1'b1;
        slot_tex[s]  = tc;
        slot_nrm[s]  = nm;
        slot_next[s] = '0;
    endfunction

    // Resolve one corner against the table and update it the way the DUT does.
    function automatic t_slot_result resolve_corner(t_corner c);
        t_slot_result r;
        int unsigned  lim, cur, steps, free_slot;
        r   = '{vertex_slot: '0, outcome: vad_pkg::OUT_BADPOS, copy_from: '0};
        lim = (base_reg > SLOTS) ? SLOTS : base_reg;
        if (c.position >= lim)
            return r;
        if (!slot_live[c.position]) begin
            claim_slot(c.position, c.texcoord, c.normal);
            r = '{vertex_slot: c.position, outcome: vad_pkg::OUT_BASE,
                  copy_from: c.position};
            return r;
        end
        // walk the chain, bounded by the table size
        cur = c.position;
        for (steps = 0; steps < SLOTS; steps++) begin
            if (slot_tex[cur] == c.texcoord && slot_nrm[cur] == c.normal) begin
                r = '{vertex_slot: cur[vad_pkg::SLOT_W-1:0], outcome: vad_pkg::OUT_REUSED,
                      copy_from: '0};
                return r;
            end
            if (slot_next[cur] == 0 || slot_next[cur] > SLOTS)
                break;
            cur = slot_next[cur] - 1;
        end
        free_slot = lim + appended;
        if (free_slot >= SLOTS) begin
            r.outcome = vad_pkg::OUT_FULL;
            return r;
        end
        slot_next[cur] = vad_pkg::BASE_W'(free_slot + 1);
        claim_slot(free_slot, c.texcoord, c.normal);
        appended = appended + 1'b1;
        r = '{vertex_slot: free_slot[vad_pkg::SLOT_W-1:0], outcome: vad_pkg::OUT_APPENDED,
              copy_from: c.position};
        return r;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what,
                     want, got);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Drop valid and hold until every owed result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_results != n_corners);
    endtask

    task automatic write_base(logic [vad_pkg::BASE_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        base_reg = value;
        n_bases++;
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one corner, optionally after a random gap; leave valid high after
    // the accept so back-to-back corners keep the line busy.
    task automatic send_corner(t_corner c, logic typed, t_slot_result typed_want);
        t_slot_result want;
        if (tx_idle_pct != 0)
            while ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, c.normal, c.texcoord, c.position};
        do @(posedge i_clk); while (!s_axis_tready);
        want = resolve_corner(c);
        pending_slots.insert(pending_slots.size(), typed ? typed_want : want);
        n_corners <= n_corners + 1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random ready, plus one long hold-off early in the random
    // part so the DUT backs up into its input.
    // ------------------------------------------------------------------------
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && n_results >= 60) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 300;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results <= n_results + 1;
            if (m_axis_tuser <= vad_pkg::OUT_BADPOS)
                seen_outcome[m_axis_tuser]++;
            if (pending_slots.size() == 0) begin
                note_mismatch("unexpected result item, outcome", -1, m_axis_tuser);
            end else begin
                want = pending_slots.pop_front();
                if (m_axis_tdata[11:0] != want.vertex_slot)
                    note_mismatch("vertex_slot", want.vertex_slot, m_axis_tdata[11:0]);
                if (m_axis_tuser != want.outcome)
                    note_mismatch("outcome", want.outcome, m_axis_tuser);
                if (m_axis_tdata[23:12] != want.copy_from)
                    note_mismatch("copy_from_position", want.copy_from,
                                  m_axis_tdata[23:12]);
            end
        end
    end

    // Cap the run; includes the post-reset clearing pass
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles,
                     pending_slots.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_corner                    c;
        t_slot_result               typed_want;
        logic [vad_pkg::POS_W-1:0]  hot_pos [16];
        logic [vad_pkg::ATTR_W-1:0] tex_pool [4];
        logic [vad_pkg::ATTR_W-1:0] nrm_pool [4];
        int                         ph, k, pick, new_base;

        base_reg = '0;
        appended = '0;
        for (k = 0; k < SLOTS; k++) begin
            slot_live[k] = 1'b0;
            slot_tex[k]  = '0;
            slot_nrm[k]  = '0;
            slot_next[k] = '0;
        end

        // hold reset, then release it on a rising edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (k = 0; k < PLAN_LEN; k++) begin
            if (PLAN[k].kind == ROW_CFG) begin
                write_base(PLAN[k].base);
            end else begin
                c          = '{PLAN[k].position, PLAN[k].texcoord, PLAN[k].normal};
                typed_want = '{PLAN[k].w_slot, PLAN[k].w_outcome, PLAN[k].w_from};
                send_corner(c, PLAN[k].typed, typed_want);
            end
        end

        // random phases: slow receiver, then slow sender, then
        // full rate with a base_count close to the top so the table overflows
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    new_base = 48;
                end
                1: begin
                    new_base = 200;
                end
                default: begin
                    new_base = SLOTS - int'(appended) - 40;
                    if (new_base < 48)
                        new_base = 48;
                end
            endcase
            write_base(vad_pkg::BASE_W'(new_base));
            tx_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 61 : 0;
            rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 16 : 0;

            // half of the hot set revisits the low positions used earlier
            for (k = 0; k < 16; k++)
                hot_pos[k] = (k % 2) ? vad_pkg::POS_W'($urandom_range(0, new_base - 1))
                                     : vad_pkg::POS_W'($urandom_range(0, 47));
            for (k = 0; k < 4; k++) begin
                tex_pool[k] = vad_pkg::ATTR_W'($urandom);
                nrm_pool[k] = vad_pkg::ATTR_W'($urandom);
            end

            for (k = 0; k < RAND_ITEMS; k++) begin
                // stop offering once in the second phase until the DUT has caught up
                if (ph == 1 && k == 100)
                    wait_drained();
                pick       = $urandom_range(99);
                c.position = hot_pos[$urandom_range(15)];
                c.texcoord = tex_pool[$urandom_range(3)];
                c.normal   = nrm_pool[$urandom_range(3)];
                if (pick >= 95) begin
                    // hot position, fresh attributes: forces a duplicate
                    c.texcoord = vad_pkg::ATTR_W'($urandom);
                    c.normal   = vad_pkg::ATTR_W'($urandom);
                end else if (pick >= 90) begin
                    // straddle the base_count boundary
                    c.position = (base_reg > 4095) ? 12'hFFF
                               : ($urandom_range(1) ? base_reg[vad_pkg::POS_W-1:0]
                                                    : vad_pkg::POS_W'(base_reg - 1));
                end else if (pick >= 80) begin
                    // noise anywhere in the field ranges
                    c.position = vad_pkg::POS_W'($urandom);
                    c.texcoord = vad_pkg::ATTR_W'($urandom);
                    c.normal   = vad_pkg::ATTR_W'($urandom);
                end
                send_corner(c, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        if (pending_slots.size() != 0)
            note_mismatch("results never delivered", 0, pending_slots.size());

        $display("Sent %0d corners under %0d base_count writes in %0d cycles.", n_corners,
                 n_bases, cycles);
        $display("Outcomes: %0d reused, %0d first use, %0d appended, %0d full, %0d bad.",
                 seen_outcome[vad_pkg::OUT_REUSED], seen_outcome[vad_pkg::OUT_BASE],
                 seen_outcome[vad_pkg::OUT_APPENDED], seen_outcome[vad_pkg::OUT_FULL],
                 seen_outcome[vad_pkg::OUT_BADPOS]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/vad_pkg.sv
hdl/vad_ram.sv
hdl/vertex_attribute_dedup.sv
sim/tb_vertex_attribute_dedup.sv
